/* rtl/trr_pkg.sv */
// shared types, codes and constants of the tftp read receiver
`default_nettype none

package trr_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned HDR_BYTES   = 4;
    localparam int unsigned FULL_LEN    = BLOCK_BYTES + HDR_BYTES;
    localparam int unsigned LEN_W       = 17;

    localparam logic [15:0] OP_DATA        = 16'd3;
    localparam logic [15:0] OP_ERROR       = 16'd5;
    localparam logic [15:0] FIRST_BLOCK    = 16'd1;
    localparam logic [15:0] RETRY_SAT      = 16'hFFFF;
    localparam logic [15:0] INIT_LIMIT_RST = 16'd5;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_PACKET  = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_IGNORE    = 3'd0,
        ACT_SEND_REQ  = 3'd1,
        ACT_STORE_ACK = 3'd2,
        ACT_FINISH    = 3'd3,
        ACT_RESEND    = 3'd4,
        ACT_FAIL      = 3'd5,
        ACT_PEER_ERR  = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RUN  = 2'd1
    } t_phase;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  pkt_len;
        logic [15:0] opcode;
        logic [15:0] block_num;
        logic [15:0] src_port;
    } t_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] ack_block;
        logic [9:0]  payload_bytes;
    } t_result;

endpackage

`default_nettype wire

/* rtl/trr_if.sv */
// valid/ready channels carrying receiver events and results
`default_nettype none

interface trr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [9:0]  pkt_len;
    logic [15:0] opcode;
    logic [15:0] block_num;
    logic [15:0] src_port;

    modport source (output valid, cmd, pkt_len, opcode, block_num, src_port, input ready);
    modport sink   (input valid, cmd, pkt_len, opcode, block_num, src_port, output ready);
endinterface

interface trr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [15:0] ack_block;
    logic [9:0]  payload_bytes;

    modport source (output valid, action, ack_block, payload_bytes, input ready);
    modport sink   (input valid, action, ack_block, payload_bytes, output ready);
endinterface

`default_nettype wire

/* rtl/tftp_read_receiver_core.sv */
// tftp read receiver: stop-and-wait receive control for a read transfer
//
// i_in carries one event per transfer: start, received packet header or
// receive timeout. o_out returns exactly one result per event: the action
// to take, the block to acknowledge and the payload byte count to store.
// i_cfg_we / i_cfg_wdata load the initial retry limit, used at the next
// start; write it only while no event is in flight.
// An event is registered on acceptance and judged once the result register
// can advance, and its result is registered there. Throughput is one event
// per cycle while o_out is not stalled, set by the single state update step
// between the input and result registers.
// When o_out is stalled, the result register holds and the input register
// fills; i_in.ready drops only once both hold an item, and follows
// o_out.ready combinationally.
// Synchronous reset empties both registers, puts the transfer in idle with
// expected block 1, no latched port, zero retries, and sets the initial
// and current retry limits to 5.
`default_nettype none

module tftp_read_receiver_core #(
    parameter int unsigned BLOCK_BYTES = trr_pkg::BLOCK_BYTES
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [15:0] i_cfg_wdata,
    trr_in_if.sink     i_in,
    trr_out_if.source  o_out
);

    logic             r_in_valid;
    trr_pkg::t_item   r_in;
    logic             r_out_valid;
    trr_pkg::t_result r_out;
    logic [15:0]      r_init_limit;

    logic             advance;
    logic             step;
    trr_pkg::t_result res;
    logic             running;

    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_limit <= trr_pkg::INIT_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_init_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= '{cmd: i_in.cmd, pkt_len: i_in.pkt_len, opcode: i_in.opcode,
                      block_num: i_in.block_num, src_port: i_in.src_port};
        end
        if (step) begin
            r_out <= res;
        end
    end

    trr_engine #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_item       (r_in),
        .i_init_limit (r_init_limit),
        .o_res        (res),
        .o_running    (running)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.action        = r_out.action;
    assign o_out.ack_block     = r_out.ack_block;
    assign o_out.payload_bytes = r_out.payload_bytes;

    // a judged event always lands in the result register
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("judged event did not reach the result register");

    // terminal actions leave the transfer idle
    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && (res.action == trr_pkg::ACT_FINISH || res.action == trr_pkg::ACT_FAIL ||
                 res.action == trr_pkg::ACT_PEER_ERR) |=> !running)
        else $error("transfer still running after a terminal action");

    // a start always arms the transfer
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && (res.action == trr_pkg::ACT_SEND_REQ) |=> running)
        else $error("start did not arm the transfer");

    // ack block and byte count only accompany store actions
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.action != trr_pkg::ACT_STORE_ACK &&
        r_out.action != trr_pkg::ACT_FINISH |->
        r_out.ack_block == 16'd0 && r_out.payload_bytes == 10'd0)
        else $error("nonzero store fields on a non-store action");

endmodule

`default_nettype wire

/* rtl/trr_engine.sv */
// transfer state and per-event decision logic of the receiver
`default_nettype none

module trr_engine #(
    parameter int unsigned BLOCK_BYTES = trr_pkg::BLOCK_BYTES
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  wire trr_pkg::t_item i_item,
    input  wire [15:0]          i_init_limit,
    output trr_pkg::t_result    o_res,
    output logic                o_running
);

    localparam logic [trr_pkg::LEN_W-1:0] FULL =
        trr_pkg::LEN_W'(BLOCK_BYTES + trr_pkg::HDR_BYTES);
    localparam logic [trr_pkg::LEN_W-1:0] HDR =
        trr_pkg::LEN_W'(trr_pkg::HDR_BYTES);

    trr_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_expected, n_expected;
    logic [15:0] r_server_port, n_server_port;
    logic        r_port_latched, n_port_latched;
    logic [15:0] r_retry_count, n_retry_count;
    logic [15:0] r_retry_limit, n_retry_limit;

    logic [15:0]              twice;
    logic [15:0]              lim_upd;
    logic [16:0]              next_count;
    logic [trr_pkg::LEN_W-1:0] len_x;
    logic [trr_pkg::LEN_W-1:0] len_c;
    logic [trr_pkg::LEN_W-1:0] pay_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= trr_pkg::PH_IDLE;
            r_expected     <= trr_pkg::FIRST_BLOCK;
            r_server_port  <= '0;
            r_port_latched <= 1'b0;
            r_retry_count  <= '0;
            r_retry_limit  <= trr_pkg::INIT_LIMIT_RST;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_expected     <= n_expected;
            r_server_port  <= n_server_port;
            r_port_latched <= n_port_latched;
            r_retry_count  <= n_retry_count;
            r_retry_limit  <= n_retry_limit;
        end
    end

    always_comb begin
        twice      = r_retry_count[15] ? trr_pkg::RETRY_SAT : {r_retry_count[14:0], 1'b0};
        lim_upd    = (twice > r_retry_limit) ? twice : r_retry_limit;
        next_count = {1'b0, r_retry_count} + 17'd1;
        len_x      = trr_pkg::LEN_W'(i_item.pkt_len);
        len_c      = (len_x > FULL) ? FULL : len_x;
        pay_x      = len_c - HDR;

        n_phase        = r_phase;
        n_expected     = r_expected;
        n_server_port  = r_server_port;
        n_port_latched = r_port_latched;
        n_retry_count  = r_retry_count;
        n_retry_limit  = r_retry_limit;
        o_res          = '{action: trr_pkg::ACT_IGNORE, ack_block: '0, payload_bytes: '0};

        case (trr_pkg::t_cmd'(i_item.cmd))
            trr_pkg::CMD_START: begin
                n_phase        = trr_pkg::PH_RUN;
                n_expected     = trr_pkg::FIRST_BLOCK;
                n_server_port  = '0;
                n_port_latched = 1'b0;
                n_retry_count  = '0;
                n_retry_limit  = i_init_limit;
                o_res.action   = trr_pkg::ACT_SEND_REQ;
            end
            trr_pkg::CMD_PACKET: begin
                // foreign port after latching is dropped without any change
                if (r_phase == trr_pkg::PH_RUN &&
                    !(r_port_latched && i_item.src_port != r_server_port)) begin
                    n_retry_limit = lim_upd;
                    n_retry_count = '0;
                    if (len_x < HDR) begin
                        n_retry_count = 16'd1;
                        o_res.action  = trr_pkg::ACT_RESEND;
                    end else begin
                        if (i_item.opcode == trr_pkg::OP_DATA &&
                            i_item.block_num == trr_pkg::FIRST_BLOCK) begin
                            n_server_port  = i_item.src_port;
                            n_port_latched = 1'b1;
                        end
                        if (i_item.opcode == trr_pkg::OP_ERROR) begin
                            n_phase      = trr_pkg::PH_IDLE;
                            o_res.action = trr_pkg::ACT_PEER_ERR;
                        end else if (i_item.opcode == trr_pkg::OP_DATA &&
                                     i_item.block_num == r_expected) begin
                            n_expected          = r_expected + 16'd1;
                            o_res.ack_block     = i_item.block_num;
                            o_res.payload_bytes = pay_x[9:0];
                            if (len_c < FULL) begin
                                n_phase      = trr_pkg::PH_IDLE;
                                o_res.action = trr_pkg::ACT_FINISH;
                            end else begin
                                o_res.action = trr_pkg::ACT_STORE_ACK;
                            end
                        end else begin
                            o_res.action = trr_pkg::ACT_RESEND;
                        end
                    end
                end
            end
            trr_pkg::CMD_TIMEOUT: begin
                if (r_phase == trr_pkg::PH_RUN) begin
                    n_retry_count = next_count[16] ? trr_pkg::RETRY_SAT : next_count[15:0];
                    if (next_count > {1'b0, r_retry_limit}) begin
                        n_phase      = trr_pkg::PH_IDLE;
                        o_res.action = trr_pkg::ACT_FAIL;
                    end else begin
                        o_res.action = trr_pkg::ACT_RESEND;
                    end
                end
            end
            default: begin
                o_res.action = trr_pkg::ACT_IGNORE;
            end
        endcase
    end

    assign o_running = (r_phase == trr_pkg::PH_RUN);

endmodule

`default_nettype wire

/* bench/testbench.sv */
// self-checking testbench of the tftp read receiver core with a built-in predictor
`default_nettype none

module testbench;
    import trr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned PHASE_ITEMS    = 140;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = 16'd0;

    trr_in_if  in_ch ();
    trr_out_if out_ch ();

    tftp_read_receiver_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predicted receiver state
    t_phase      xfer_phase = PH_IDLE;
    logic [15:0] want_block = FIRST_BLOCK;
    logic [15:0] peer_port  = 16'd0;
    logic        port_held  = 1'b0;
    logic [15:0] retries    = 16'd0;
    logic [15:0] limit_now  = INIT_LIMIT_RST;
    logic [15:0] limit_init = INIT_LIMIT_RST;

    t_item       event_q[$];
    t_result     due_results[$];
    t_item       drv_item;
    t_item       seen_item;
    t_result     got_result;
    t_result     want_result;

    int unsigned acc_in = 0;
    int unsigned acc_out = 0;
    int unsigned idle_cycles = 0;
    int unsigned hold_left = 0;
    int          fail_cnt = 0;
    bit          hold_done = 1'b0;
    bit          in_taken = 1'b0;
    bit          steady;

    assign steady = (acc_in >= 400) && (acc_in < 650);

    function automatic t_result judge_event(input t_item it);
        t_result     r;
        logic [16:0] twice;
        logic [16:0] nxt;
        logic [9:0]  len;
        r = '0;
        r.action = ACT_IGNORE;
        case (it.cmd)
            CMD_START: begin
                xfer_phase = PH_RUN;
                want_block = FIRST_BLOCK;
                peer_port  = 16'd0;
                port_held  = 1'b0;
                retries    = 16'd0;
                limit_now  = limit_init;
                r.action   = ACT_SEND_REQ;
            end
            CMD_PACKET: begin
                if (xfer_phase == PH_RUN && !(port_held && it.src_port != peer_port)) begin
                    // an answered round raises the limit to twice its retries if that is larger
                    twice = {retries, 1'b0};
                    if (twice > {1'b0, RETRY_SAT}) twice = {1'b0, RETRY_SAT};
                    if (twice[15:0] > limit_now) limit_now = twice[15:0];
                    retries = 16'd0;
                    if (it.pkt_len < HDR_BYTES) begin
                        retries  = 16'd1;
                        r.action = ACT_RESEND;
                    end else begin
                        if (it.opcode == OP_DATA && it.block_num == FIRST_BLOCK) begin
                            peer_port = it.src_port;
                            port_held = 1'b1;
                        end
                        if (it.opcode == OP_ERROR) begin
                            xfer_phase = PH_IDLE;
                            r.action   = ACT_PEER_ERR;
                        end else if (it.opcode == OP_DATA && it.block_num == want_block) begin
                            len = (it.pkt_len > FULL_LEN) ? 10'(FULL_LEN) : it.pkt_len;
                            r.ack_block     = it.block_num;
                            r.payload_bytes = len - 10'(HDR_BYTES);
                            want_block      = want_block + 16'd1;
                            if (len < FULL_LEN) begin
                                xfer_phase = PH_IDLE;
                                r.action   = ACT_FINISH;
                            end else begin
                                r.action = ACT_STORE_ACK;
                            end
                        end else begin
                            r.action = ACT_RESEND;
                        end
                    end
                end
            end
            CMD_TIMEOUT: begin
                if (xfer_phase == PH_RUN) begin
                    nxt = {1'b0, retries} + 17'd1;
                    retries = (nxt > {1'b0, RETRY_SAT}) ? RETRY_SAT : nxt[15:0];
                    if (nxt > {1'b0, limit_now}) begin
                        xfer_phase = PH_IDLE;
                        r.action   = ACT_FAIL;
                    end else begin
                        r.action = ACT_RESEND;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        fail_cnt++;
        $display("mismatch on %s at result %0d: got %0d, want %0d", what, acc_out, got, want);
    endtask

    // input transfers, output transfers, predictor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) limit_init = i_cfg_wdata;
            if (out_ch.valid && out_ch.ready) begin
                got_result.action        = out_ch.action;
                got_result.ack_block     = out_ch.ack_block;
                got_result.payload_bytes = out_ch.payload_bytes;
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result action", 16'(got_result.action), 16'd0);
                end else begin
                    want_result = due_results.pop_front();
                    if (got_result.action != want_result.action)
                        report_mismatch("action", 16'(got_result.action),
                                        16'(want_result.action));
                    if (got_result.ack_block != want_result.ack_block)
                        report_mismatch("ack_block", got_result.ack_block,
                                        want_result.ack_block);
                    if (got_result.payload_bytes != want_result.payload_bytes)
                        report_mismatch("payload_bytes", 16'(got_result.payload_bytes),
                                        16'(want_result.payload_bytes));
                end
                acc_out++;
            end
            in_taken = in_ch.valid && in_ch.ready;
            if (in_taken) begin
                seen_item.cmd       = in_ch.cmd;
                seen_item.pkt_len   = in_ch.pkt_len;
                seen_item.opcode    = in_ch.opcode;
                seen_item.block_num = in_ch.block_num;
                seen_item.src_port  = in_ch.src_port;
                due_results.push_back(judge_event(seen_item));
                acc_in++;
            end
            if (in_taken || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("testbench failed");
                    $finish;
                end
            end
        end
    end

    // sender: next event once the current one has been transferred
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (event_q.size() != 0 && (steady || $urandom_range(0, 99) >= 19)) begin
                drv_item = event_q.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.cmd       <= drv_item.cmd;
                in_ch.pkt_len   <= drv_item.pkt_len;
                in_ch.opcode    <= drv_item.opcode;
                in_ch.block_num <= drv_item.block_num;
                in_ch.src_port  <= drv_item.src_port;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off that backs up the input
    always @(negedge i_clk) begin
        if (!hold_done && acc_in >= 300) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady || ($urandom_range(0, 99) >= 19);
        end
    end

    task automatic queue_event(input t_cmd c, input int unsigned len, input int unsigned op,
                               input int unsigned blk, input int unsigned port);
        t_item it;
        it.cmd       = c;
        it.pkt_len   = len[9:0];
        it.opcode    = op[15:0];
        it.block_num = blk[15:0];
        it.src_port  = port[15:0];
        event_q.push_back(it);
    endtask

    task automatic queue_bare(input t_cmd c);
        queue_event(c, $urandom_range(0, 1023), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    // one disturbance inside a transfer waiting for block blk from port
    task automatic queue_noise(input int unsigned port, input int unsigned blk);
        int unsigned k;
        case ($urandom_range(0, 6))
            0: begin
                k = $urandom_range(1, 3);
                repeat (k) queue_bare(CMD_TIMEOUT);
            end
            1: queue_event(CMD_PACKET, $urandom_range(0, 3), $urandom_range(0, 65535),
                           blk, port);
            2: queue_event(CMD_PACKET, FULL_LEN, OP_DATA,
                           ($urandom_range(0, 1) != 0) ? blk - 1 : $urandom_range(0, 65535),
                           port);
            3: queue_event(CMD_PACKET, FULL_LEN, OP_DATA, blk, port ^ $urandom_range(1, 65535));
            4: queue_event(CMD_PACKET, $urandom_range(4, 1023), $urandom_range(0, 65535),
                           blk, port);
            5: queue_bare(CMD_NONE);
            default: queue_bare(t_cmd'($urandom_range(1, 3)));
        endcase
    endtask

    task automatic queue_transfer(input int unsigned lim);
        int unsigned port;
        int unsigned nblk;
        int unsigned blk;
        int unsigned k;
        int unsigned pick;
        port = $urandom_range(0, 65535);
        queue_bare(CMD_START);
        nblk = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 6);
        for (blk = 1; blk <= nblk; blk++) begin
            while ($urandom_range(0, 3) == 0) queue_noise(port, blk);
            queue_event(CMD_PACKET,
                        ($urandom_range(0, 4) == 0) ? $urandom_range(FULL_LEN + 1, 1023)
                                                    : FULL_LEN,
                        OP_DATA, blk, port);
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            queue_event(CMD_PACKET, $urandom_range(HDR_BYTES, FULL_LEN - 1), OP_DATA,
                        nblk + 1, port);
        end else if (pick < 7) begin
            queue_event(CMD_PACKET, $urandom_range(HDR_BYTES, 1023), OP_ERROR,
                        $urandom_range(0, 65535),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : port);
        end else if (pick < 9) begin
            // run the retries out where the limit is small enough
            k = (lim <= 20) ? lim + 1 + $urandom_range(0, 2) : $urandom_range(1, 10);
            repeat (k) queue_bare(CMD_TIMEOUT);
        end
    endtask

    task automatic drain;
        while (event_q.size() != 0 || in_ch.valid || due_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_retry_limit(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    logic [15:0] settings[6];
    int unsigned port_a;
    int unsigned goal;
    int          s;

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_NONE;
        in_ch.pkt_len   = 10'd0;
        in_ch.opcode    = 16'd0;
        in_ch.block_num = 16'd0;
        in_ch.src_port  = 16'd0;
        out_ch.ready    = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset retry limit
        port_a = 16'hA5C3;
        queue_event(CMD_PACKET, FULL_LEN, OP_DATA, 1, port_a);   // idle packet
        queue_bare(CMD_TIMEOUT);                                 // idle timeout
        queue_bare(CMD_NONE);
        queue_event(CMD_START, 0, 0, 0, 0);
        queue_event(CMD_PACKET, FULL_LEN, OP_DATA, 1, port_a);   // latches the port
        queue_event(CMD_PACKET, FULL_LEN, OP_DATA, 2, 16'h5A3C); // foreign port
        queue_bare(CMD_NONE);
        queue_event(CMD_PACKET, 3, OP_DATA, 2, port_a);          // short packet
        queue_bare(CMD_TIMEOUT);
        queue_event(CMD_PACKET, FULL_LEN, OP_DATA, 1, port_a);   // stale block
        queue_event(CMD_PACKET, 1023, OP_DATA, 2, port_a);       // oversized data
        queue_event(CMD_PACKET, FULL_LEN, 16'hFFFF, 3, port_a);  // unexpected opcode
        queue_event(CMD_PACKET, 0, 0, 0, port_a);
        queue_event(CMD_PACKET, HDR_BYTES, OP_DATA, 3, port_a);  // empty final block
        queue_event(CMD_START, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_bare(CMD_START);                                   // restart while running
        repeat (6) queue_bare(CMD_TIMEOUT);                      // runs out the limit
        queue_bare(CMD_START);
        queue_event(CMD_PACKET, HDR_BYTES, OP_ERROR, 0, 0);      // peer error
        drain();

        settings[0] = 16'd1;
        settings[1] = 16'hFFFF;
        settings[2] = 16'd0;
        settings[3] = 16'd3;
        settings[4] = 16'($urandom_range(2, 12));
        settings[5] = 16'd7;
        for (s = 0; s < 6; s++) begin
            load_retry_limit(settings[s]);
            goal = event_q.size() + PHASE_ITEMS;
            while (event_q.size() < goal) queue_transfer(settings[s]);
            drain();
        end
        repeat (8) @(negedge i_clk);

        if (fail_cnt == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
